### rtl/core/gcsb_pkg.sv
// Package for the grid cell signature and bucket block.
// Hash constants, configuration codes, the flow-control struct and small bit helpers.
// No dependencies.
`default_nettype none

package gcsb_pkg;

  localparam int HASH_FN_COUNT = 2;
  localparam int NUM_STAGES    = 9;
  localparam int BUCKET_W      = 20;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LAYOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNATURE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LOG2    = 2'd2;

  // layout and mode codes
  localparam logic [1:0] LAYOUT_4D      = 2'd2;
  localparam logic [1:0] MODE_XXHASH    = 2'd1;
  localparam logic [1:0] MODE_ZORDER    = 2'd2;

  localparam logic [4:0] BUCKET_LOG2_RESET = 5'd10;
  localparam logic [4:0] BUCKET_LOG2_MAX   = 5'd20;

  localparam logic [31:0] M1      = 32'd73856093;
  localparam logic [31:0] M2      = 32'd19349663;
  localparam logic [31:0] M3      = 32'd83492791;
  localparam logic [31:0] XP2     = 32'd2246822519;
  localparam logic [31:0] XP3     = 32'd3266489917;
  localparam logic [31:0] XP4     = 32'd668265263;
  localparam logic [31:0] XP5     = 32'd374761393;
  localparam logic [31:0] PCG_MUL = 32'd747796405;
  localparam logic [31:0] PCG_ADD = 32'd2891336453;
  localparam logic [31:0] PCG_FIN = 32'd277803737;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic                  in_ready;
    logic                  out_valid;
  } gcsb_flow_t;

  function automatic logic [31:0] rotl17(input logic [31:0] v);
    return {v[14:0], v[31:15]};
  endfunction

  // Z-order, 3D: bit j of axis d lands at 3j+d, anything past bit 31 drops
  function automatic logic [31:0] morton3(input logic [31:0] ux, input logic [31:0] uy,
                                          input logic [31:0] uz);
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 11; j++) begin
      r[3*j] = ux[j];
      if (3*j+1 < 32) r[3*j+1] = uy[j];
      if (3*j+2 < 32) r[3*j+2] = uz[j];
    end
    return r;
  endfunction

  // Z-order, 4D: low byte of each axis, bit b of axis d at 4b+d
  function automatic logic [31:0] morton4(input logic [31:0] ux, input logic [31:0] uy,
                                          input logic [31:0] uz, input logic [31:0] ut);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      r[4*b]   = ux[b];
      r[4*b+1] = uy[b];
      r[4*b+2] = uz[b];
      r[4*b+3] = ut[b];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/gcsb_if.sv
// Valid/ready channel interfaces for the grid cell signature block.
// Cell index items in, signature and bucket items out. No dependencies.
`default_nettype none

interface gcsb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] idx_x;
  logic signed [31:0] idx_y;
  logic signed [31:0] idx_z;
  logic signed [31:0] idx_t;

  modport source (output valid, idx_x, idx_y, idx_z, idx_t, input ready);
  modport sink   (input valid, idx_x, idx_y, idx_z, idx_t, output ready);
endinterface

interface gcsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cell_signature;
  logic [19:0] bucket_primary;
  logic [19:0] bucket_alt;

  modport source (output valid, cell_signature, bucket_primary, bucket_alt, input ready);
  modport sink   (input valid, cell_signature, bucket_primary, bucket_alt, output ready);
endinterface

`default_nettype wire

### rtl/core/gcsb_flow.sv
// Valid bits and per-stage load enables for the hash pipeline.
// A stage loads when it is empty or its successor loads, so bubbles squeeze out.
// Depends on gcsb_pkg.
`default_nettype none

module gcsb_flow import gcsb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_ready,
  output gcsb_flow_t flow
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = ~valid_r[NUM_STAGES-1] | out_ready;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      load[k] = ~valid_r[k] | load[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load[0]) valid_nxt[0] = in_valid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) valid_nxt[k] = valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign flow.load      = load;
  assign flow.in_ready  = load[0];
  assign flow.out_valid = valid_r[NUM_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/grid_cell_signature_and_buckets.sv
// Grid cell signature and bucket indices: a nine-stage pipeline that takes one cell index
// item per cycle unless the output stalls, and delivers its 32-bit signature with two
// bucket indices from its output register. The stages follow the longest multiply chain,
// the xxHash32 path (three word rounds, two finalizer multiplies) followed by the two
// multiplies of the PCG rehash, each given its own register stage. Stalls on the output
// hold the pipe without losing items; empty stages fill while the output waits.
// Configuration writes take effect at once and are meant for an idle pipeline.
// Depends on gcsb_pkg, gcsb_if and gcsb_flow.
`default_nettype none

module grid_cell_signature_and_buckets import gcsb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  gcsb_in_if.sink                    in_item,
  gcsb_out_if.source                 out_item
);

  logic [1:0]  layout_r;
  logic [1:0]  mode_r;
  logic [4:0]  log2_r;
  logic        four;
  logic [4:0]  lg;
  logic [BUCKET_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= '0;
      mode_r   <= '0;
      log2_r   <= BUCKET_LOG2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_LAYOUT:    layout_r <= cfg_data[1:0];
        CFG_SIGNATURE_MODE: mode_r   <= cfg_data[1:0];
        CFG_BUCKET_LOG2:    log2_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign four = (layout_r == LAYOUT_4D);
  assign lg   = (log2_r > BUCKET_LOG2_MAX) ? BUCKET_LOG2_MAX : log2_r;
  assign mask = ~({BUCKET_W{1'b1}} << lg);

  gcsb_flow_t flow;

  gcsb_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .out_ready (out_item.ready),
    .flow      (flow)
  );

  assign in_item.ready  = flow.in_ready;
  assign out_item.valid = flow.out_valid;

  // stage 1: all word products, multiply-xor and Z-order signatures
  logic [31:0] ux, uy, uz, ut;
  logic [31:0] mx_y, mx_z, mx_t, sig_mx, sig_z;
  logic [31:0] s1_a_r, s1_p1_r, s1_p2_r, s1_p3_r, s1_other_r;

  assign ux = in_item.idx_x;
  assign uy = in_item.idx_y;
  assign uz = in_item.idx_z;
  assign ut = in_item.idx_t;

  always_comb begin
    mx_y   = M1 * uy;
    mx_z   = M2 * uz;
    mx_t   = M3 * ut;
    sig_mx = ux ^ mx_y ^ mx_z ^ (four ? mx_t : 32'd0);
    sig_z  = four ? morton4(ux, uy, uz, ut) : morton3(ux, uy, uz);
  end

  always_ff @(posedge clk) begin
    if (flow.load[0]) begin
      s1_a_r     <= ux + XP5;
      s1_p1_r    <= XP3 * uy;
      s1_p2_r    <= XP3 * uz;
      s1_p3_r    <= XP3 * ut;
      s1_other_r <= (mode_r == MODE_ZORDER) ? sig_z : sig_mx;
    end
  end

  // stages 2..4: xxHash32 word rounds
  logic [31:0] s2_x_r, s2_p2_r, s2_p3_r, s2_other_r;
  logic [31:0] s3_x_r, s3_p3_r, s3_other_r;
  logic [31:0] s4_x_r, s4_other_r;

  always_ff @(posedge clk) begin
    if (flow.load[1]) begin
      s2_x_r     <= XP4 * rotl17(s1_a_r + s1_p1_r);
      s2_p2_r    <= s1_p2_r;
      s2_p3_r    <= s1_p3_r;
      s2_other_r <= s1_other_r;
    end
    if (flow.load[2]) begin
      s3_x_r     <= XP4 * rotl17(s2_x_r + s2_p2_r);
      s3_p3_r    <= s2_p3_r;
      s3_other_r <= s2_other_r;
    end
    if (flow.load[3]) begin
      s4_x_r     <= four ? XP4 * rotl17(s3_x_r + s3_p3_r) : s3_x_r;
      s4_other_r <= s3_other_r;
    end
  end

  // stages 5..6: xxHash32 avalanche
  logic [31:0] s5_h_r, s5_other_r;
  logic [31:0] s6_h_r, s6_other_r;

  always_ff @(posedge clk) begin
    if (flow.load[4]) begin
      s5_h_r     <= XP2 * (s4_x_r ^ (s4_x_r >> 15));
      s5_other_r <= s4_other_r;
    end
    if (flow.load[5]) begin
      s6_h_r     <= XP3 * (s5_h_r ^ (s5_h_r >> 13));
      s6_other_r <= s5_other_r;
    end
  end

  // stage 7: pick the signature, start the PCG rehash
  logic [31:0] sig7;
  logic [31:0] s7_sig_r, s7_h_r;

  assign sig7 = (mode_r == MODE_XXHASH) ? (s6_h_r ^ (s6_h_r >> 16)) : s6_other_r;

  always_ff @(posedge clk) begin
    if (flow.load[6]) begin
      s7_sig_r <= sig7;
      s7_h_r   <= sig7 * PCG_MUL + PCG_ADD;
    end
  end

  // stage 8: PCG output permutation, data-dependent shift of 4..19
  logic [4:0]  pcg_sh;
  logic [31:0] s8_sig_r, s8_h_r;

  assign pcg_sh = {1'b0, s7_h_r[31:28]} + 5'd4;

  always_ff @(posedge clk) begin
    if (flow.load[7]) begin
      s8_sig_r <= s7_sig_r;
      s8_h_r   <= ((s7_h_r >> pcg_sh) ^ s7_h_r) * PCG_FIN;
    end
  end

  // stage 9: output register
  logic [31:0] alt_full;
  logic [31:0] s9_sig_r;
  logic [BUCKET_W-1:0] s9_prim_r, s9_alt_r;

  assign alt_full = (HASH_FN_COUNT > 1) ? ((s8_h_r >> 22) ^ s8_h_r) : s8_sig_r;

  always_ff @(posedge clk) begin
    if (flow.load[8]) begin
      s9_sig_r  <= s8_sig_r;
      s9_prim_r <= s8_sig_r[BUCKET_W-1:0] & mask;
      s9_alt_r  <= alt_full[BUCKET_W-1:0] & mask;
    end
  end

  assign out_item.cell_signature = s9_sig_r;
  assign out_item.bucket_primary = s9_prim_r;
  assign out_item.bucket_alt     = s9_alt_r;

endmodule

`default_nettype wire
